/* design/health_alarm_supervisor_assert.svh */
// Assertion macros for the health alarm supervisor.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef HEALTH_ALARM_SUPERVISOR_ASSERT_SVH
`define HEALTH_ALARM_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HAS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("health alarm supervisor check failed");

// Next-cycle implication, checked out of reset.
`define HAS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("health alarm supervisor check failed");

`endif

/* design/hlth_pkg.sv */
// Shared types and constants of the health alarm supervisor.
// No dependencies; imported by every module of the block.
package hlth_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MASK_W     = 11;
    localparam int PCT_W      = 7;

    localparam logic [PCT_W-1:0] FILL_PCT_MAX = 7'd100;
    localparam logic [PCT_W-1:0] FILL_SCALE   = 7'd100;
    localparam logic [31:0]      COUNT_MAX    = 32'hFFFF_FFFF;

    // Alarm bit positions.
    localparam int ALM_SUPPLY   = 0;
    localparam int ALM_BATTERY  = 1;
    localparam int ALM_TEMP     = 2;
    localparam int ALM_WATCHDOG = 3;
    localparam int ALM_HEAP     = 4;
    localparam int ALM_BOOTLOOP = 5;
    localparam int ALM_HEALTH   = 6;
    localparam int ALM_LEAK     = 7;
    localparam int ALM_SENSOR   = 8;
    localparam int ALM_VIB      = 9;
    localparam int ALM_SPOOL    = 10;

    // Event flag bit positions.
    localparam int FLG_POWER_VALID = 0;
    localparam int FLG_BOOTLOOP    = 1;
    localparam int FLG_HEALTH      = 2;
    localparam int FLG_ENV_VALID   = 3;
    localparam int FLG_LEAK        = 4;
    localparam int FLG_INGRESS     = 5;
    localparam int FLG_PRESSURE    = 6;
    localparam int FLG_VIB_LIMIT   = 7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ENABLE     = 3'd0,
        REG_MIN_SUPPLY = 3'd1,
        REG_MIN_BATT   = 3'd2,
        REG_MAX_TEMP   = 3'd3,
        REG_STALE_LIM  = 3'd4,
        REG_MIN_HEAP   = 3'd5,
        REG_MAX_VIB    = 3'd6,
        REG_FILL_PCT   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        STAT_CLEAR = 2'd0,
        STAT_ALARM = 2'd1,
        STAT_OFF   = 2'd2
    } t_status;

    typedef logic [MASK_W-1:0] t_mask;

    typedef struct packed {
        logic                enable;
        logic [15:0]         min_supply_mv;
        logic [15:0]         min_batt_mv;
        logic signed [15:0]  max_temp_c;
        logic [31:0]         feed_stale_limit_ms;
        logic [31:0]         min_heap_free;
        logic [15:0]         max_vibration;
        logic [PCT_W-1:0]    max_fill_percent;
    } t_cfg;

    typedef struct packed {
        logic [15:0]         supply_mv;
        logic [15:0]         batt_mv;
        logic signed [15:0]  temp_c;
        logic [31:0]         now_ms;
        logic [31:0]         feed_time_ms;
        logic [31:0]         heap_free;
        logic [15:0]         vibration;
        logic [31:0]         spool_used;
        logic [31:0]         spool_size;
        logic [7:0]          event_flags;
    } t_poll;

endpackage

/* design/hlth_cfg.sv */
// Configuration register file of the health alarm supervisor.
// Depends on hlth_pkg for the register index codes and the t_cfg struct.
module hlth_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hlth_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [hlth_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output hlth_pkg::t_cfg                      o_cfg
);
    import hlth_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_ENABLE:     n_cfg.enable              = i_cfg_data[0];
                REG_MIN_SUPPLY: n_cfg.min_supply_mv       = i_cfg_data[15:0];
                REG_MIN_BATT:   n_cfg.min_batt_mv         = i_cfg_data[15:0];
                REG_MAX_TEMP:   n_cfg.max_temp_c          = $signed(i_cfg_data[15:0]);
                REG_STALE_LIM:  n_cfg.feed_stale_limit_ms = i_cfg_data[31:0];
                REG_MIN_HEAP:   n_cfg.min_heap_free       = i_cfg_data[31:0];
                REG_MAX_VIB:    n_cfg.max_vibration       = i_cfg_data[15:0];
                REG_FILL_PCT: begin
                    // Values above full scale in the low PCT_W data bits are refused; the old value stays.
                    if (i_cfg_data[PCT_W-1:0] <= FILL_PCT_MAX) begin
                        n_cfg.max_fill_percent = i_cfg_data[PCT_W-1:0];
                    end
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/hlth_eval.sv */
// Alarm mask evaluation: threshold compares, watchdog age and spool fill check.
// Depends on hlth_pkg for the poll and configuration structs and bit positions.
module hlth_eval (
    input  hlth_pkg::t_poll  i_poll,
    input  hlth_pkg::t_cfg   i_cfg,
    output hlth_pkg::t_mask  o_mask
);
    import hlth_pkg::*;

    logic        power_ok;
    logic        env_ok;
    logic [31:0] feed_age;
    logic [38:0] fill_used;
    logic [38:0] fill_limit;
    logic        vib_high;

    assign power_ok = i_poll.event_flags[FLG_POWER_VALID];
    assign env_ok   = i_poll.event_flags[FLG_ENV_VALID];

    // Uptime wraps, so the age is taken modulo 2^32.
    assign feed_age = i_poll.now_ms - i_poll.feed_time_ms;

    // Both products fit in 39 bits, so the compare never wraps.
    assign fill_used  = 39'(i_poll.spool_used) * 39'(FILL_SCALE);
    assign fill_limit = 39'(i_poll.spool_size) * 39'(i_cfg.max_fill_percent);

    assign vib_high = (i_cfg.max_vibration != 16'd0)
                   && (i_poll.vibration > i_cfg.max_vibration);

    always_comb begin
        o_mask = '0;
        o_mask[ALM_SUPPLY]   = power_ok && (i_cfg.min_supply_mv != 16'd0)
                            && (i_poll.supply_mv < i_cfg.min_supply_mv);
        o_mask[ALM_BATTERY]  = power_ok && (i_cfg.min_batt_mv != 16'd0)
                            && (i_poll.batt_mv < i_cfg.min_batt_mv);
        o_mask[ALM_TEMP]     = power_ok && (i_cfg.max_temp_c != 16'sd0)
                            && ($signed(i_poll.temp_c) > $signed(i_cfg.max_temp_c));
        o_mask[ALM_WATCHDOG] = (i_cfg.feed_stale_limit_ms != 32'd0)
                            && (i_poll.feed_time_ms != 32'd0)
                            && (feed_age > i_cfg.feed_stale_limit_ms);
        o_mask[ALM_HEAP]     = (i_cfg.min_heap_free != 32'd0)
                            && (i_poll.heap_free < i_cfg.min_heap_free);
        o_mask[ALM_BOOTLOOP] = i_poll.event_flags[FLG_BOOTLOOP];
        o_mask[ALM_HEALTH]   = i_poll.event_flags[FLG_HEALTH];
        o_mask[ALM_LEAK]     = env_ok && (i_poll.event_flags[FLG_LEAK]
                            || i_poll.event_flags[FLG_INGRESS]);
        o_mask[ALM_SENSOR]   = env_ok && i_poll.event_flags[FLG_PRESSURE];
        o_mask[ALM_VIB]      = env_ok && (i_poll.event_flags[FLG_VIB_LIMIT] || vib_high);
        o_mask[ALM_SPOOL]    = (i_cfg.max_fill_percent != '0)
                            && (i_poll.spool_size != 32'd0)
                            && (fill_used >= fill_limit);
    end

endmodule

/* design/health_alarm_supervisor.sv */
// Health alarm supervisor top level: poll register, alarm state and result register.
// Depends on hlth_pkg, hlth_cfg, hlth_eval and health_alarm_supervisor_assert.svh.
//
//   channel | direction | handshake                 | payload
//   poll    | in        | i_in_valid / o_in_stall   | supply .. event_flags
//   result  | out       | o_out_valid / i_out_stall | alarm_mask .. status
//   config  | in        | i_cfg_we                  | i_cfg_addr, i_cfg_data
//
// One poll word is taken per cycle while o_in_stall is low; its result word is loaded
// once the result register is free (poll register, compare logic, then result register).
// The alarm state is updated at the same edge that loads the result register,
// so back-to-back polls see each other's masks. Reset is synchronous and clears
// configuration, alarm state and both valid flags. A stalled result holds the
// result register; one more poll can wait in the poll register behind it.
`include "health_alarm_supervisor_assert.svh"

module health_alarm_supervisor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [15:0]                       i_supply_mv,
    input  logic [15:0]                       i_batt_mv,
    input  logic signed [15:0]                i_temp_c,
    input  logic [31:0]                       i_now_ms,
    input  logic [31:0]                       i_feed_time_ms,
    input  logic [31:0]                       i_heap_free,
    input  logic [15:0]                       i_vibration,
    input  logic [31:0]                       i_spool_used,
    input  logic [31:0]                       i_spool_size,
    input  logic [7:0]                        i_event_flags,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hlth_pkg::MASK_W-1:0]       o_alarm_mask,
    output logic [hlth_pkg::MASK_W-1:0]       o_prior_mask,
    output logic                              o_changed,
    output logic [hlth_pkg::MASK_W-1:0]       o_raised_mask,
    output logic [31:0]                       o_change_count,
    output logic [31:0]                       o_change_time_ms,
    output logic [1:0]                        o_status,
    input  logic                              i_cfg_we,
    input  logic [hlth_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [hlth_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hlth_pkg::*;

    t_cfg    cfg;
    t_mask   mask;
    t_poll   r_poll;
    logic    r_in_valid;
    logic    out_free;
    logic    in_free;
    logic    advance;
    logic    mask_diff;
    logic    res_off;
    logic    res_on;

    // Alarm state.
    t_mask       r_active_mask;
    t_mask       r_prior_mask;
    logic [31:0] r_change_count;
    logic [31:0] r_change_time;
    t_mask       n_active_mask;
    t_mask       n_prior_mask;
    logic [31:0] n_change_count;
    logic [31:0] n_change_time;

    // Result register.
    logic        r_out_valid;
    t_mask       r_alarm_mask;
    t_mask       r_res_prior;
    logic        r_changed;
    t_mask       r_raised_mask;
    logic [31:0] r_res_count;
    logic [31:0] r_res_time;
    t_status     r_status;
    t_status     n_status;

    hlth_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    hlth_eval u_eval (
        .i_poll (r_poll),
        .i_cfg  (cfg),
        .o_mask (mask)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_free    = !r_in_valid || out_free;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_poll.supply_mv    <= i_supply_mv;
            r_poll.batt_mv      <= i_batt_mv;
            r_poll.temp_c       <= i_temp_c;
            r_poll.now_ms       <= i_now_ms;
            r_poll.feed_time_ms <= i_feed_time_ms;
            r_poll.heap_free    <= i_heap_free;
            r_poll.vibration    <= i_vibration;
            r_poll.spool_used   <= i_spool_used;
            r_poll.spool_size   <= i_spool_size;
            r_poll.event_flags  <= i_event_flags;
        end
    end

    assign mask_diff = (mask != r_active_mask);

    // A disabled block reports its stored state and leaves it untouched.
    always_comb begin
        n_active_mask  = r_active_mask;
        n_prior_mask   = r_prior_mask;
        n_change_count = r_change_count;
        n_change_time  = r_change_time;
        n_status       = STAT_OFF;
        if (cfg.enable) begin
            n_active_mask = mask;
            n_prior_mask  = r_active_mask;
            if (mask_diff) begin
                if (r_change_count != COUNT_MAX) begin
                    n_change_count = r_change_count + 32'd1;
                end
                n_change_time = r_poll.now_ms;
            end
            n_status = (mask != '0) ? STAT_ALARM : STAT_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_mask  <= '0;
            r_prior_mask   <= '0;
            r_change_count <= '0;
            r_change_time  <= '0;
        end else if (advance) begin
            r_active_mask  <= n_active_mask;
            r_prior_mask   <= n_prior_mask;
            r_change_count <= n_change_count;
            r_change_time  <= n_change_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_alarm_mask  <= n_active_mask;
            r_res_prior   <= n_prior_mask;
            r_changed     <= cfg.enable && mask_diff;
            r_raised_mask <= cfg.enable ? (mask & ~r_active_mask) : '0;
            r_res_count   <= n_change_count;
            r_res_time    <= n_change_time;
            r_status      <= n_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_alarm_mask     = r_alarm_mask;
    assign o_prior_mask     = r_res_prior;
    assign o_changed        = r_changed;
    assign o_raised_mask    = r_raised_mask;
    assign o_change_count   = r_res_count;
    assign o_change_time_ms = r_res_time;
    assign o_status         = r_status;

    assign res_off = r_out_valid && (r_status == STAT_OFF);
    assign res_on  = r_out_valid && (r_status != STAT_OFF);

    `HAS_ASSERT_NEXT(a_active_matches_result, advance, r_active_mask == r_alarm_mask)
    `HAS_ASSERT_NEXT(a_prior_matches_result, advance, r_prior_mask == r_res_prior)
    `HAS_ASSERT_NEXT(a_count_never_drops, advance, r_change_count >= $past(r_change_count))
    `HAS_ASSERT_NOW(a_off_reports_no_change, res_off, !r_changed && (r_raised_mask == '0))
    `HAS_ASSERT_NOW(a_changed_consistent, res_on, r_changed == (r_alarm_mask != r_res_prior))

endmodule
